// File: design/lcoe_pkg.sv
// Package for the latency cache: shared types, codes and constants.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package lcoe_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int CAP_W           = 7;
    localparam int TICK_W          = 32;
    localparam int ADDR_W          = 32;
    localparam int PORT_W          = 16;
    localparam int LAT_W           = 32;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd64;
    localparam logic [TICK_W-1:0] EXPIRY_RESET = 32'd1000000;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_PURGE  = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_EXPIRY   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture input item, clear scan
        logic step;   // examine entry under scan pointer, advance
        logic commit; // apply final write / count update
        logic result; // set the output valid register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // scan pointer has reached the end of live entries, or a key matched (not purge)
        logic empty;     // no live entries to scan
        logic is_tick;   // current item needs no scan
    } status_t;

endpackage

// File: design/lcoe_ctrl.sv
// Controller state machine for the latency cache.
// Depends on lcoe_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
module lcoe_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_busy,
    input  lcoe_pkg::status_t  status,
    output lcoe_pkg::cmd_t     cmd
);
    import lcoe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !out_busy)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.is_tick || status.empty)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_busy;
                cmd.load = in_valid && !out_busy;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.commit = 1'b1;
            end
            ST_DONE:
            begin
                cmd.result = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: design/lcoe_dp.sv
// Datapath for the latency cache: entry memory, scan pointer, tick counter.
// Depends on lcoe_pkg; commanded by lcoe_ctrl.
`timescale 1ns / 1ps
module lcoe_dp
#(
    parameter int ENTRIES = lcoe_pkg::ENTRIES_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lcoe_pkg::cmd_t              cmd,
    output lcoe_pkg::status_t           status,
    input  logic [1:0]                  action,
    input  logic [lcoe_pkg::ADDR_W-1:0] peer_addr,
    input  logic [lcoe_pkg::PORT_W-1:0] peer_port,
    input  logic [lcoe_pkg::LAT_W-1:0]  new_latency,
    input  logic [lcoe_pkg::CAP_W-1:0]  capacity_limit,
    input  logic [lcoe_pkg::TICK_W-1:0] expiry_ticks,
    output logic                        res_hit,
    output logic [lcoe_pkg::LAT_W-1:0]  res_latency,
    output logic                        res_replaced,
    output logic [lcoe_pkg::CAP_W-1:0]  res_occupancy
);
    import lcoe_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [LAT_W-1:0]  lat;
        logic [TICK_W-1:0] stamp;
    } entry_t;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    action_t           act_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PORT_W-1:0] port_reg;
    logic [LAT_W-1:0]  lat_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  wr_ptr_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [LAT_W-1:0]  found_lat_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TICK_W-1:0] best_age_reg;
    logic              hit_reg;
    logic [LAT_W-1:0]  lat_out_reg;
    logic              repl_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic [TICK_W-1:0] age;
    logic              key_eq;
    logic              keep;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [CNT_W-1:0]  rd_ptr_inc;

    assign rd_ptr_inc = rd_ptr_reg + CNT_W'(1);

    always_comb
    begin
        if (capacity_limit == '0 || 32'(capacity_limit) > 32'(ENTRIES))
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_limit);
        end
    end

    assign age    = tick_reg - rd_data_reg.stamp;
    assign key_eq = (rd_data_reg.addr == addr_reg) && (rd_data_reg.port == port_reg);
    assign keep   = age < expiry_ticks;

    assign status.is_tick   = (act_reg == ACT_TICK);
    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (rd_ptr_inc >= count_reg)
                              || (act_reg != ACT_PURGE && found_reg)
                              || (act_reg != ACT_PURGE && key_eq);

    // memory read: registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rd_data_reg;
        if (cmd.step && act_reg == ACT_PURGE && keep)
        begin
            mem_we    = (wr_ptr_reg != rd_ptr_reg);
            mem_waddr = wr_ptr_reg[IDX_W-1:0];
        end
        else if (cmd.commit && act_reg == ACT_INSERT)
        begin
            mem_we          = 1'b1;
            mem_wdata.addr  = addr_reg;
            mem_wdata.port  = port_reg;
            mem_wdata.lat   = lat_reg;
            mem_wdata.stamp = tick_reg;
            if (found_reg)
            begin
                mem_waddr = found_idx_reg;
            end
            else if (count_reg < eff_cap)
            begin
                mem_waddr = count_reg[IDX_W-1:0];
            end
            else
            begin
                mem_waddr = best_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            tick_reg   <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            found_reg  <= 1'b0;
            act_reg    <= ACT_TICK;
        end
        else if (cmd.load)
        begin
            act_reg    <= action_t'(action);
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            found_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            rd_ptr_reg <= rd_ptr_inc;
            if (act_reg == ACT_PURGE)
            begin
                if (keep)
                begin
                    wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
                end
            end
            else if (key_eq && !found_reg)
            begin
                found_reg <= 1'b1;
            end
        end
        else if (cmd.commit)
        begin
            unique case (act_reg)
                ACT_INSERT:
                begin
                    if (!found_reg && count_reg < eff_cap)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ACT_PURGE:
                begin
                    if (count_reg != '0)
                    begin
                        count_reg <= wr_ptr_reg;
                    end
                end
                ACT_TICK:
                begin
                    tick_reg <= tick_reg + TICK_W'(1);
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg     <= peer_addr;
            port_reg     <= peer_port;
            lat_reg      <= new_latency;
            best_age_reg <= '0;
            best_idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (key_eq && !found_reg)
            begin
                found_idx_reg <= rd_ptr_reg[IDX_W-1:0];
                found_lat_reg <= rd_data_reg.lat;
            end
            if (rd_ptr_reg == '0 || age > best_age_reg)
            begin
                best_age_reg <= age;
                best_idx_reg <= rd_ptr_reg[IDX_W-1:0];
            end
        end
        if (cmd.commit)
        begin
            hit_reg     <= (act_reg == ACT_INSERT || act_reg == ACT_LOOKUP) && found_reg;
            lat_out_reg <= (act_reg == ACT_LOOKUP && found_reg) ? found_lat_reg : '0;
            repl_reg    <= (act_reg == ACT_INSERT) && !found_reg && !(count_reg < eff_cap);
        end
    end

    assign res_hit       = hit_reg;
    assign res_latency   = lat_out_reg;
    assign res_replaced  = repl_reg;
    assign res_occupancy = CAP_W'(count_reg);

endmodule

// File: design/latency_cache_oldest_evict_top.sv
// Latency cache: each item scans its N live entries in turn
// (up to ENTRIES; insert/lookup stop at the first key match); no scan
// (tick, empty table). States: IDLE, READ and SCAN per entry, WRITE, DONE.
// A new item is taken only in IDLE, once the last one has passed DONE.
// Result sits in an output register; next item is taken once it is moved.
// Reset (rst_n, async low) empties the table, clears the tick counter and
// returns the registers to capacity 64 and expiry 1000000.
`timescale 1ns / 1ps
module latency_cache_oldest_evict_top
#(
    parameter int ENTRIES = lcoe_pkg::ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // peer_addr, peer_port, new_latency
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // latency_out, occupancy, zero pad
    output logic [1:0]  m_axis_tuser,  // hit, replaced_oldest
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import lcoe_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [CAP_W-1:0]  cap_reg;
    logic [TICK_W-1:0] expiry_reg;
    logic              out_valid_reg;
    logic              res_hit;
    logic [LAT_W-1:0]  res_latency;
    logic              res_replaced;
    logic [CAP_W-1:0]  res_occupancy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            expiry_reg <= EXPIRY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CAPACITY: cap_reg    <= cfg_wdata[CAP_W-1:0];
                REG_EXPIRY:   expiry_reg <= cfg_wdata;
                default:      cap_reg    <= cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    lcoe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_busy (out_valid_reg && !m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcoe_dp #(.ENTRIES(ENTRIES)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (s_axis_tuser),
        .peer_addr      (s_axis_tdata[31:0]),
        .peer_port      (s_axis_tdata[47:32]),
        .new_latency    (s_axis_tdata[79:48]),
        .capacity_limit (cap_reg),
        .expiry_ticks   (expiry_reg),
        .res_hit        (res_hit),
        .res_latency    (res_latency),
        .res_replaced   (res_replaced),
        .res_occupancy  (res_occupancy)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_occupancy, res_latency};
    assign m_axis_tuser  = {res_replaced, res_hit};

endmodule

// File: design/lcoe_checker.sv
// Port-level checker for the latency cache, bound to the top level.
// Depends on latency_cache_oldest_evict_top port names only.
`timescale 1ns / 1ps
module lcoe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // no result is shown before the item taken in has passed READ, WRITE and DONE
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result too early");

    // no input is taken in the cycle right after one was taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("back-to-back accept");

    // hit and replacement never both set
    a_hit_repl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit with replacement");

    // occupancy never exceeds 64 at default depth
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:32] <= 7'd64))
        else $error("occupancy out of range");
endmodule

bind latency_cache_oldest_evict_top lcoe_checker u_lcoe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
